/* rtl/tle_pkg.sv */
package tle_pkg;

    localparam int LINE_CAP_DEF   = 64;
    localparam int HIST_DEPTH_DEF = 8;

    typedef enum logic [3:0] {
        K_NONE      = 4'd0,
        K_ECHO      = 4'd1,
        K_LEFT      = 4'd2,
        K_RIGHT     = 4'd3,
        K_REDRAW    = 4'd4,
        K_REDRAW_E  = 4'd5,
        K_LINE_CHAR = 4'd6,
        K_ENTER_E   = 4'd7,
        K_CANCEL    = 4'd8
    } kind_t;

    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CH_DEL  = 8'd127;
    localparam logic [7:0] CH_BS   = 8'd8;
    localparam logic [7:0] CH_ETX  = 8'd3;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_SP   = 8'd32;
    localparam logic [7:0] CH_LBR  = 8'h5b;
    localparam logic [7:0] CH_UP   = 8'h41;
    localparam logic [7:0] CH_DOWN = 8'h42;
    localparam logic [7:0] CH_RGT  = 8'h43;
    localparam logic [7:0] CH_LFT  = 8'h44;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LINE_RD,    // read line[addr]
        OP_LINE_WR,    // line[addr] <= wdata
        OP_HIST_RD,    // read hist[slot][addr]
        OP_HIST_WR,    // hist[slot][addr] <= wdata
        OP_LEN_RD,     // read hist length[slot]
        OP_LEN_WR      // hist length[slot] <= wdata
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [5:0] addr;
        logic [4:0] slot;
        logic [7:0] wdata;
    } dp_cmd_t;

    typedef struct packed {
        logic [7:0] line_q;
        logic [7:0] hist_q;
        logic [5:0] len_q;
    } dp_stat_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        upcase = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    endfunction

endpackage

/* rtl/terminal_line_editor_history.sv */
// channel | ports                                   | dir
// input   | s_valid s_ready s_rx_byte               | in
// result  | m_valid m_ready m_kind m_char_out       | out
//         | m_cursor m_length m_last                |
// one byte at a time. a shift, history compare, copy or recall, and a redraw or
// delivery, steps through the line one character at a time over the single
// read port of each memory.
// synchronous active-low reset; memories are not cleared.
// a stalled result beat holds the sweep; no new byte is taken until done.
module terminal_line_editor_history
    import tle_pkg::*;
#(
    parameter int LINE_CAP   = LINE_CAP_DEF,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_kind,
    output logic [7:0] m_char_out,
    output logic [5:0] m_cursor,
    output logic [5:0] m_length,
    output logic       m_last
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    tle_ctrl #(.LINE_CAP(LINE_CAP), .HIST_DEPTH(HIST_DEPTH)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_rx_byte,
        .m_valid, .m_ready, .m_kind, .m_char_out, .m_cursor, .m_length, .m_last,
        .cmd, .stat
    );

    tle_datapath #(.LINE_CAP(LINE_CAP), .HIST_DEPTH(HIST_DEPTH)) u_dp (
        .aclk, .cmd, .stat
    );
endmodule

/* rtl/tle_datapath.sv */
module tle_datapath
    import tle_pkg::*;
#(
    parameter int LINE_CAP   = LINE_CAP_DEF,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
    input  logic     aclk,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat
);
    localparam int AW = $clog2(LINE_CAP);
    localparam int SW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    logic [7:0] line_mem [LINE_CAP];
    logic [7:0] hist_mem [HIST_DEPTH*(2**AW)];
    logic [5:0] len_mem  [HIST_DEPTH];

    logic [7:0] line_q_reg, hist_q_reg;
    logic [5:0] len_q_reg;

    logic [AW-1:0] a;
    logic [SW-1:0] s;
    logic [SW+AW-1:0] ha;

    assign a  = cmd.addr[AW-1:0];
    assign s  = cmd.slot[SW-1:0];
    assign ha = {s, a};

    // edit line memory
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LINE_WR) line_mem[a] <= cmd.wdata;
        line_q_reg <= line_mem[a];
    end

    // history character memory
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_HIST_WR) hist_mem[ha] <= cmd.wdata;
        hist_q_reg <= hist_mem[ha];
    end

    // history length table
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LEN_WR) len_mem[s] <= cmd.wdata[5:0];
        len_q_reg <= len_mem[s];
    end

    assign stat.line_q = line_q_reg;
    assign stat.hist_q = hist_q_reg;
    assign stat.len_q  = len_q_reg;
endmodule

/* rtl/tle_ctrl.sv */
module tle_ctrl
    import tle_pkg::*;
#(
    parameter int LINE_CAP   = LINE_CAP_DEF,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_kind,
    output logic [7:0] m_char_out,
    output logic [5:0] m_cursor,
    output logic [5:0] m_length,
    output logic       m_last,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);
    localparam logic [5:0] LMAX = 6'(LINE_CAP - 1);
    localparam logic [5:0] HD   = 6'(HIST_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_OUT,
        S_SHR_RD, S_SHR_WT, S_SHR_WR,      // insert shift right
        S_SHL_RD, S_SHL_WT, S_SHL_WR,      // delete shift left
        S_RD_RD, S_RD_WT, S_RD_OUT,        // redraw / deliver sweep
        S_CMP_LEN, S_CMP_LWT, S_CMP_RD, S_CMP_WT, S_CMP_CHK,
        S_CPY_RD, S_CPY_WT, S_CPY_WR,      // line -> history
        S_LD_LEN, S_LD_LWT, S_LD_N, S_LD_RD, S_LD_WT, S_LD_WR, // history -> line
        S_RIGHT_WT, S_SEND_LINE
    } state_t;

    state_t     state_reg;
    logic [7:0] ch_reg;
    logic [5:0] len_reg, cur_reg, i_reg, n_reg;
    logic [1:0] esc_reg;
    logic [5:0] cnt_reg, rec_reg;
    logic [4:0] old_reg;
    logic [4:0] slot_reg;
    logic [3:0] kind_reg, sweep_kind_reg;
    logic [7:0] och_reg;
    logic       last_reg, mval_reg;
    state_t     ret_reg;
    dp_cmd_t    cmd_reg;

    // ring slot of a logical index
    function automatic logic [4:0] slot_of(input logic [4:0] o, input logic [5:0] l);
        logic [6:0] t;
        t = {2'b00, o} + {1'b0, l};
        if (t >= {1'b0, HD}) t = t - {1'b0, HD};
        slot_of = t[4:0];
    endfunction

    function automatic logic [4:0] inc_slot(input logic [4:0] o);
        inc_slot = (({1'b0, o} + 6'd1) >= HD) ? 5'd0 : o + 5'd1;
    endfunction

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = mval_reg;
    assign m_kind     = kind_reg;
    assign m_char_out = och_reg;
    assign m_cursor   = cur_reg;
    assign m_length   = len_reg;
    assign m_last     = last_reg;
    assign cmd        = cmd_reg;

    // controller: state, counters and the result register
    always_ff @(posedge aclk) begin
        cmd_reg.op <= OP_IDLE;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            cur_reg   <= '0;
            esc_reg   <= '0;
            cnt_reg   <= '0;
            old_reg   <= '0;
            rec_reg   <= '0;
            mval_reg  <= 1'b0;
            cmd_reg   <= '{op: OP_IDLE, addr: '0, slot: '0, wdata: '0};
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        ch_reg    <= s_rx_byte;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    kind_reg <= K_NONE;
                    och_reg  <= '0;
                    last_reg <= 1'b1;
                    state_reg <= S_OUT;
                    if (esc_reg == 2'd1) begin
                        esc_reg <= (ch_reg == CH_LBR) ? 2'd2 : 2'd0;
                    end else if (esc_reg == 2'd2) begin
                        esc_reg <= 2'd0;
                        if (ch_reg == CH_UP) begin
                            if (cnt_reg != '0 && (rec_reg >= cnt_reg || rec_reg != '0)) begin
                                rec_reg <= (rec_reg >= cnt_reg) ? cnt_reg - 6'd1
                                                                : rec_reg - 6'd1;
                                slot_reg <= slot_of(old_reg, (rec_reg >= cnt_reg) ?
                                                    cnt_reg - 6'd1 : rec_reg - 6'd1);
                                state_reg <= S_LD_LEN;
                            end
                        end else if (ch_reg == CH_DOWN) begin
                            if (cnt_reg != '0 && rec_reg < cnt_reg) begin
                                if (rec_reg + 6'd1 < cnt_reg) begin
                                    rec_reg  <= rec_reg + 6'd1;
                                    slot_reg <= slot_of(old_reg, rec_reg + 6'd1);
                                    state_reg <= S_LD_LEN;
                                end else begin
                                    len_reg <= '0;
                                    cur_reg <= '0;
                                    rec_reg <= cnt_reg;
                                    kind_reg <= K_REDRAW_E;
                                end
                            end
                        end else if (ch_reg == CH_RGT) begin
                            if (cur_reg < len_reg) begin
                                cmd_reg.op   <= OP_LINE_RD;
                                cmd_reg.addr <= cur_reg;
                                state_reg <= S_RIGHT_WT;
                            end
                        end else if (ch_reg == CH_LFT) begin
                            if (cur_reg > 0) begin
                                cur_reg  <= cur_reg - 6'd1;
                                kind_reg <= K_LEFT;
                            end
                        end
                    end else begin
                        esc_reg <= 2'd0;
                        if (ch_reg == CH_ESC) begin
                            esc_reg <= 2'd1;
                        end else if (ch_reg == CH_CR || ch_reg == CH_LF) begin
                            if (len_reg == 0) begin
                                kind_reg <= K_ENTER_E;
                                rec_reg  <= cnt_reg;
                            end else if (cnt_reg != '0) begin
                                slot_reg  <= slot_of(old_reg, cnt_reg - 6'd1);
                                state_reg <= S_CMP_LEN;
                            end else begin
                                state_reg <= S_CPY_RD;
                                slot_reg  <= slot_of(old_reg, cnt_reg);
                                cnt_reg   <= cnt_reg + 6'd1;
                                i_reg     <= '0;
                            end
                        end else if (ch_reg == CH_BS || ch_reg == CH_DEL) begin
                            if (cur_reg != 0) begin
                                i_reg     <= cur_reg - 6'd1;
                                state_reg <= S_SHL_RD;
                            end
                        end else if (ch_reg == CH_ETX) begin
                            len_reg <= '0;
                            cur_reg <= '0;
                            rec_reg <= cnt_reg;
                            kind_reg <= K_CANCEL;
                        end else if (ch_reg >= CH_SP && ch_reg < CH_DEL) begin
                            if (len_reg < LMAX) begin
                                if (cur_reg == len_reg) begin
                                    cmd_reg.op    <= OP_LINE_WR;
                                    cmd_reg.addr  <= len_reg;
                                    cmd_reg.wdata <= ch_reg;
                                    len_reg  <= len_reg + 6'd1;
                                    cur_reg  <= len_reg + 6'd1;
                                    kind_reg <= K_ECHO;
                                    och_reg  <= ch_reg;
                                end else begin
                                    i_reg     <= len_reg;
                                    state_reg <= S_SHR_RD;
                                end
                            end
                        end
                    end
                end
                // single result beat out, then idle
                S_OUT: begin
                    if (!mval_reg) mval_reg <= 1'b1;
                    else if (m_ready) begin
                        mval_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_RIGHT_WT: state_reg <= S_SEND_LINE;
                S_SEND_LINE: begin
                    kind_reg  <= K_RIGHT;
                    och_reg   <= stat.line_q;
                    cur_reg   <= cur_reg + 6'd1;
                    state_reg <= S_OUT;
                end
                // insert: move line[i-1] to line[i] down to the cursor
                S_SHR_RD: begin
                    if (i_reg > cur_reg) begin
                        cmd_reg.op   <= OP_LINE_RD;
                        cmd_reg.addr <= i_reg - 6'd1;
                        state_reg    <= S_SHR_WT;
                    end else begin
                        cmd_reg.op    <= OP_LINE_WR;
                        cmd_reg.addr  <= cur_reg;
                        cmd_reg.wdata <= ch_reg;
                        len_reg <= len_reg + 6'd1;
                        cur_reg <= cur_reg + 6'd1;
                        n_reg   <= len_reg + 6'd1;
                        sweep_kind_reg <= K_REDRAW;
                        i_reg     <= '0;
                        state_reg <= S_RD_RD;
                    end
                end
                S_SHR_WT: state_reg <= S_SHR_WR;
                S_SHR_WR: begin
                    cmd_reg.op    <= OP_LINE_WR;
                    cmd_reg.addr  <= i_reg;
                    cmd_reg.wdata <= stat.line_q;
                    i_reg     <= i_reg - 6'd1;
                    state_reg <= S_SHR_RD;
                end
                // delete: move line[i+1] to line[i]
                S_SHL_RD: begin
                    if (i_reg + 6'd1 < len_reg) begin
                        cmd_reg.op   <= OP_LINE_RD;
                        cmd_reg.addr <= i_reg + 6'd1;
                        state_reg    <= S_SHL_WT;
                    end else begin
                        len_reg <= len_reg - 6'd1;
                        cur_reg <= cur_reg - 6'd1;
                        n_reg   <= len_reg - 6'd1;
                        sweep_kind_reg <= K_REDRAW;
                        i_reg     <= '0;
                        state_reg <= S_RD_RD;
                    end
                end
                S_SHL_WT: state_reg <= S_SHL_WR;
                S_SHL_WR: begin
                    cmd_reg.op    <= OP_LINE_WR;
                    cmd_reg.addr  <= i_reg;
                    cmd_reg.wdata <= stat.line_q;
                    i_reg     <= i_reg + 6'd1;
                    state_reg <= S_SHL_RD;
                end
                // sweep n characters of the line out as result beats; an empty line gives one K_REDRAW_E beat
                S_RD_RD: begin
                    if (n_reg == '0) begin
                        kind_reg  <= K_REDRAW_E;
                        och_reg   <= '0;
                        last_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        cmd_reg.op   <= OP_LINE_RD;
                        cmd_reg.addr <= i_reg;
                        state_reg    <= S_RD_WT;
                    end
                end
                S_RD_WT: begin
                    kind_reg  <= sweep_kind_reg;
                    state_reg <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    if (!mval_reg) begin
                        och_reg  <= stat.line_q;
                        last_reg <= (i_reg + 6'd1 == n_reg);
                        mval_reg <= 1'b1;
                    end else if (m_ready) begin
                        mval_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            i_reg     <= i_reg + 6'd1;
                            state_reg <= S_RD_RD;
                        end
                    end
                end
                // compare with newest history entry
                S_CMP_LEN: begin
                    cmd_reg.op   <= OP_LEN_RD;
                    cmd_reg.slot <= slot_reg;
                    state_reg    <= S_CMP_LWT;
                end
                S_CMP_LWT: state_reg <= S_CMP_RD;
                S_CMP_RD: begin
                    state_reg <= S_CMP_CHK;
                    i_reg     <= '0;
                    n_reg     <= stat.len_q;
                end
                S_CMP_CHK: begin
                    if (n_reg != len_reg) begin
                        i_reg     <= '0;
                        state_reg <= S_CPY_RD;
                        if (cnt_reg < HD) begin
                            slot_reg <= slot_of(old_reg, cnt_reg);
                            cnt_reg  <= cnt_reg + 6'd1;
                        end else begin
                            slot_reg <= old_reg;
                            old_reg  <= inc_slot(old_reg);
                        end
                    end else if (i_reg == len_reg) begin
                        // duplicate of the newest entry: deliver and clear
                        n_reg          <= len_reg;
                        len_reg        <= '0;
                        cur_reg        <= '0;
                        rec_reg        <= cnt_reg;
                        i_reg          <= '0;
                        sweep_kind_reg <= K_LINE_CHAR;
                        state_reg      <= S_RD_RD;
                    end else begin
                        cmd_reg.op   <= OP_LINE_RD;
                        cmd_reg.addr <= i_reg;
                        cmd_reg.slot <= slot_reg;
                        state_reg    <= S_CMP_WT;
                    end
                end
                S_CMP_WT: begin
                    cmd_reg.op <= OP_HIST_RD;
                    state_reg  <= S_CPY_WT;
                    ret_reg    <= S_CMP_CHK;
                end
                // copy line into history slot
                S_CPY_RD: begin
                    if (i_reg == len_reg) begin
                        cmd_reg.op    <= OP_LEN_WR;
                        cmd_reg.slot  <= slot_reg;
                        cmd_reg.wdata <= {2'b00, len_reg};
                        // deliver the line, the editor is already cleared
                        n_reg          <= len_reg;
                        len_reg        <= '0;
                        cur_reg        <= '0;
                        rec_reg        <= cnt_reg;
                        i_reg          <= '0;
                        sweep_kind_reg <= K_LINE_CHAR;
                        state_reg      <= S_RD_RD;
                    end else begin
                        cmd_reg.op   <= OP_LINE_RD;
                        cmd_reg.addr <= i_reg;
                        ret_reg      <= S_CPY_WR;
                        state_reg    <= S_CPY_WT;
                    end
                end
                S_CPY_WT: begin
                    state_reg <= ret_reg;
                end
                S_CPY_WR: begin
                    cmd_reg.op    <= OP_HIST_WR;
                    cmd_reg.addr  <= i_reg;
                    cmd_reg.slot  <= slot_reg;
                    cmd_reg.wdata <= stat.line_q;
                    i_reg     <= i_reg + 6'd1;
                    state_reg <= S_CPY_RD;
                end
                // recall history entry into the line
                S_LD_LEN: begin
                    cmd_reg.op   <= OP_LEN_RD;
                    cmd_reg.slot <= slot_reg;
                    state_reg    <= S_LD_LWT;
                end
                S_LD_LWT: state_reg <= S_LD_N;
                S_LD_N: begin
                    n_reg     <= (stat.len_q > LMAX) ? LMAX : stat.len_q;
                    i_reg     <= '0;
                    state_reg <= S_LD_RD;
                end
                S_LD_RD: begin
                    if (i_reg == n_reg) begin
                        len_reg <= n_reg;
                        cur_reg <= n_reg;
                        i_reg   <= '0;
                        sweep_kind_reg <= K_REDRAW;
                        state_reg <= S_RD_RD;
                    end else begin
                        cmd_reg.op   <= OP_HIST_RD;
                        cmd_reg.addr <= i_reg;
                        cmd_reg.slot <= slot_reg;
                        state_reg    <= S_LD_WT;
                    end
                end
                S_LD_WT: state_reg <= S_LD_WR;
                S_LD_WR: begin
                    cmd_reg.op    <= OP_LINE_WR;
                    cmd_reg.addr  <= i_reg;
                    cmd_reg.wdata <= stat.hist_q;
                    i_reg     <= i_reg + 6'd1;
                    state_reg <= S_LD_RD;
                end
                default: state_reg <= S_IDLE;
            endcase
            // compare step: check the fetched pair
            if (state_reg == S_CPY_WT && ret_reg == S_CMP_CHK) begin
                if (upcase(stat.hist_q) != upcase(stat.line_q)) n_reg <= ~len_reg;
                else i_reg <= i_reg + 6'd1;
            end
        end
    end
endmodule

/* rtl/tle_checker.sv */
module tle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_kind,
    input logic [5:0] m_cursor,
    input logic [5:0] m_length,
    input logic       m_last
);
    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_last))
        else $error("result beat changed while stalled");
    // no input taken while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready during result");
    // cursor never past length
    a_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cursor <= m_length)
        else $error("cursor beyond line");
    // kind stays within the code set
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind <= 4'd8)
        else $error("bad kind");
endmodule

bind terminal_line_editor_history tle_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_kind, .m_cursor, .m_length, .m_last
);

/* sim/tb_terminal_line_editor_history.sv */
module tb_terminal_line_editor_history;
    import tle_pkg::*;

    localparam int LCAP  = LINE_CAP_DEF;
    localparam int HDEP  = HIST_DEPTH_DEF;
    localparam int NRAND = 276;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic [5:0] cur;
        logic [5:0] len;
        logic       last;
    } event_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [3:0] m_kind;
    logic [7:0] m_char_out;
    logic [5:0] m_cursor;
    logic [5:0] m_length;
    logic       m_last;

    logic [7:0] byte_q[$];
    event_t     expected_events[$];
    int         errors;
    bit         stim_done;
    bit         in_taken;

    // editor shadow state
    logic [7:0] ed_line[LCAP];
    int         ed_len, ed_cur, esc_phase;
    logic [7:0] hist_chars[HDEP][LCAP];
    int         hist_len[HDEP];
    int         hist_cnt, hist_old, recall_pos;
    event_t     step_ev[$];

    terminal_line_editor_history u_dut (.*);

    // clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic void put_event(input kind_t k, input logic [7:0] c);
        event_t e;
        if (step_ev.size() >= LCAP) return;
        e = '0;
        e.kind = k;
        e.ch = c;
        step_ev.push_back(e);
    endfunction

    function automatic void show_line();
        if (ed_len == 0) put_event(K_REDRAW_E, 8'd0);
        for (int i = 0; i < ed_len; i++) put_event(K_REDRAW, ed_line[i]);
    endfunction

    function automatic int slot_at(input int lg);
        return (hist_old + lg) % HDEP;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic void clear_edit();
        ed_len = 0;
        ed_cur = 0;
        recall_pos = hist_cnt;
    endfunction

    function automatic void recall(input int lg);
        int s;
        s = slot_at(lg);
        ed_len = hist_len[s];
        for (int i = 0; i < ed_len; i++) ed_line[i] = hist_chars[s][i];
        ed_cur = ed_len;
        show_line();
    endfunction

    function automatic void save_history();
        int  s;
        bit  same;
        if (hist_cnt > 0) begin
            s = slot_at(hist_cnt - 1);
            if (hist_len[s] == ed_len) begin
                same = 1;
                for (int i = 0; i < ed_len; i++)
                    if (fold_case(hist_chars[s][i]) != fold_case(ed_line[i])) same = 0;
                if (same) return;
            end
        end
        if (hist_cnt < HDEP) begin
            s = slot_at(hist_cnt);
            hist_cnt++;
        end else begin
            s = hist_old;
            hist_old = (hist_old + 1) % HDEP;
        end
        for (int i = 0; i < ed_len; i++) hist_chars[s][i] = ed_line[i];
        hist_len[s] = ed_len;
    endfunction

    function automatic void handle_arrow(input logic [7:0] c);
        if (c == CH_UP) begin
            if (hist_cnt == 0) put_event(K_NONE, 8'd0);
            else if (recall_pos >= hist_cnt) begin
                recall_pos = hist_cnt - 1;
                recall(recall_pos);
            end else if (recall_pos > 0) begin
                recall_pos--;
                recall(recall_pos);
            end else put_event(K_NONE, 8'd0);
        end else if (c == CH_DOWN) begin
            if (hist_cnt == 0 || recall_pos >= hist_cnt) put_event(K_NONE, 8'd0);
            else if (recall_pos + 1 < hist_cnt) begin
                recall_pos++;
                recall(recall_pos);
            end else begin
                clear_edit();
                show_line();
            end
        end else if (c == CH_RGT) begin
            if (ed_cur < ed_len) begin
                put_event(K_RIGHT, ed_line[ed_cur]);
                ed_cur++;
            end else put_event(K_NONE, 8'd0);
        end else if (c == CH_LFT) begin
            if (ed_cur > 0) begin
                ed_cur--;
                put_event(K_LEFT, 8'd0);
            end else put_event(K_NONE, 8'd0);
        end else put_event(K_NONE, 8'd0);
    endfunction

    // predict the display events caused by one received byte
    function automatic void predict_byte(input logic [7:0] c);
        step_ev.delete();
        if (esc_phase == 1) begin
            esc_phase = (c == CH_LBR) ? 2 : 0;
            put_event(K_NONE, 8'd0);
        end else if (esc_phase == 2) begin
            esc_phase = 0;
            handle_arrow(c);
        end else if (c == CH_ESC) begin
            esc_phase = 1;
            put_event(K_NONE, 8'd0);
        end else if (c == CH_CR || c == CH_LF) begin
            if (ed_len > 0) begin
                save_history();
                for (int i = 0; i < ed_len; i++) put_event(K_LINE_CHAR, ed_line[i]);
            end else put_event(K_ENTER_E, 8'd0);
            clear_edit();
        end else if (c == CH_BS || c == CH_DEL) begin
            if (ed_cur == 0) put_event(K_NONE, 8'd0);
            else begin
                for (int i = ed_cur - 1; i + 1 < ed_len; i++) ed_line[i] = ed_line[i + 1];
                ed_len--;
                ed_cur--;
                show_line();
            end
        end else if (c == CH_ETX) begin
            clear_edit();
            put_event(K_CANCEL, 8'd0);
        end else if (c >= CH_SP && c < CH_DEL) begin
            if (ed_len >= LCAP - 1) put_event(K_NONE, 8'd0);
            else if (ed_cur == ed_len) begin
                ed_line[ed_len] = c;
                ed_len++;
                ed_cur = ed_len;
                put_event(K_ECHO, c);
            end else begin
                for (int i = ed_len; i > ed_cur; i--) ed_line[i] = ed_line[i - 1];
                ed_line[ed_cur] = c;
                ed_len++;
                ed_cur++;
                show_line();
            end
        end else put_event(K_NONE, 8'd0);
        if (step_ev.size() == 0) put_event(K_NONE, 8'd0);
        foreach (step_ev[i]) begin
            step_ev[i].cur = ed_cur[5:0];
            step_ev[i].len = ed_len[5:0];
            step_ev[i].last = (i == step_ev.size() - 1);
            expected_events.push_back(step_ev[i]);
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // remember an input beat taken at the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
    end

    // input driver
    int send_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                s_rx_byte <= byte_q.pop_front();
                s_valid <= 1'b1;
                send_gap = gap_len();
            end else begin
                s_valid <= 1'b0;
                stim_done = 1;
            end
        end
    end

    // receiver backpressure
    int stall_cnt;
    always @(negedge aclk) begin
        if (stall_cnt > 0) begin
            stall_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_cnt = gap_len();
        end
    end

    // predict on input beats, check result beats
    always @(posedge aclk) begin
        event_t e;
        if (aresetn && s_valid && s_ready) predict_byte(s_rx_byte);
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                $error("result beat with nothing expected: kind %0d", m_kind);
                errors++;
            end else begin
                e = expected_events.pop_front();
                if (m_kind !== e.kind) begin
                    $error("kind: expected %0d got %0d", e.kind, m_kind); errors++;
                end
                if (m_char_out !== e.ch) begin
                    $error("char_out: expected %0d got %0d", e.ch, m_char_out); errors++;
                end
                if (m_cursor !== e.cur) begin
                    $error("cursor: expected %0d got %0d", e.cur, m_cursor); errors++;
                end
                if (m_length !== e.len) begin
                    $error("length: expected %0d got %0d", e.len, m_length); errors++;
                end
                if (m_last !== e.last) begin
                    $error("last: expected %0d got %0d", e.last, m_last); errors++;
                end
            end
        end
    end

    function automatic void push_word(input string w);
        for (int i = 0; i < w.len(); i++) byte_q.push_back(w[i]);
    endfunction

    function automatic void push_arrow(input logic [7:0] a);
        byte_q.push_back(CH_ESC);
        byte_q.push_back(CH_LBR);
        byte_q.push_back(a);
    endfunction

    function automatic logic [7:0] rand_printable();
        return $urandom_range(32, 126);
    endfunction

    function automatic logic [7:0] rand_key();
        int r;
        logic [7:0] arrows[4];
        arrows = '{CH_UP, CH_DOWN, CH_RGT, CH_LFT};
        r = $urandom_range(0, 99);
        if (r < 45) return rand_printable();
        if (r < 55) return ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
        if (r < 62) return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
        if (r < 64) return CH_ETX;
        if (r < 70) return $urandom_range(0, 255);
        return arrows[$urandom_range(0, 3)];
    endfunction

    // stimulus
    initial begin
        int n;
        logic [7:0] k;
        errors = 0;
        stim_done = 0;
        stall_cnt = 0;
        s_valid = 1'b0;
        s_rx_byte = 8'd0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        ed_len = 0; ed_cur = 0; esc_phase = 0;
        hist_cnt = 0; hist_old = 0; recall_pos = 0;

        // directed: edges, empty enter, moves, history
        byte_q.push_back(CH_CR);
        push_arrow(CH_UP);
        push_arrow(CH_DOWN);
        push_arrow(CH_LFT);
        byte_q.push_back(CH_BS);
        push_word("ab~");
        push_arrow(CH_LFT);
        push_arrow(CH_LFT);
        byte_q.push_back(8'h20);
        push_arrow(CH_RGT);
        byte_q.push_back(CH_DEL);
        byte_q.push_back(CH_LF);
        push_word("A~");
        byte_q.push_back(CH_CR);
        byte_q.push_back(CH_ESC);
        byte_q.push_back(CH_ESC);
        byte_q.push_back(8'hff);
        push_word("z");
        byte_q.push_back(CH_ETX);
        byte_q.push_back(8'h80);
        byte_q.push_back(8'd0);

        // fill a line to capacity then overflow, then commit
        for (int i = 0; i < LCAP; i++) byte_q.push_back(rand_printable());
        push_arrow(CH_UP);
        push_arrow(CH_UP);
        push_arrow(CH_DOWN);
        push_arrow(CH_DOWN);
        push_arrow(CH_UP);
        byte_q.push_back(CH_CR);

        // random sessions: mostly short lines and edits with escapes
        n = 0;
        while (n < NRAND) begin
            if ($urandom_range(0, 9) < 7) begin
                k = rand_key();
                if (k == CH_UP || k == CH_DOWN || k == CH_RGT || k == CH_LFT) begin
                    if ($urandom_range(0, 9) == 0) begin
                        byte_q.push_back(CH_ESC);
                        byte_q.push_back($urandom_range(0, 255));
                        n += 2;
                    end else begin
                        push_arrow(k);
                        n += 3;
                    end
                end else begin
                    byte_q.push_back(k);
                    n++;
                end
            end else begin
                // a short committed line, sometimes a case-flipped repeat
                for (int i = 0; i < $urandom_range(1, 6); i++) begin
                    byte_q.push_back(($urandom_range(0, 1) != 0) ?
                                     8'($urandom_range(97, 100)) : 8'($urandom_range(65, 68)));
                    n++;
                end
                byte_q.push_back(CH_CR);
                n++;
            end
        end
        // a second long line to hit the cap again
        for (int i = 0; i < LCAP; i++) byte_q.push_back(rand_printable());
        byte_q.push_back(CH_LF);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (stim_done && byte_q.size() == 0 && !s_valid);
        wait (expected_events.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0 && expected_events.size() == 0)
            $display("terminal_line_editor_history regression: pass");
        else
            $display("terminal_line_editor_history regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #250000000;
        $display("terminal_line_editor_history regression: fail");
        $finish;
    end

endmodule

/* terminal_line_editor_history.f */
rtl/tle_pkg.sv
rtl/tle_datapath.sv
rtl/tle_ctrl.sv
rtl/terminal_line_editor_history.sv
rtl/tle_checker.sv
sim/tb_terminal_line_editor_history.sv
